>>> rtl/core/bdsl_pkg.sv
// shared types and constants for the button debounce short/long press unit
`default_nettype none
package bdsl_pkg;

  localparam int unsigned DebWidth  = 16;
  localparam int unsigned HeldWidth = 32;
  localparam int unsigned CfgIdxWidth  = 8;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 40;

  localparam logic [DebWidth-1:0]  DebResetVal  = 16'd20;
  localparam logic [HeldWidth-1:0] LongResetVal = 32'd3000;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgDebounceTicks  = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CfgLongPressTicks = 8'd1;

  // one press report
  typedef struct packed {
    logic [HeldWidth-1:0] held_ticks_out;
    logic                 long_press;
  } press_result_t;

  // tracker status seen by the top level
  typedef struct packed {
    logic pressed;
    logic held_nonzero;
    logic long_seen;
  } trk_status_t;

endpackage
`default_nettype wire

>>> rtl/core/button_debounce_short_long_press_unit.sv
// button debounce with short/long press reporting, top level
// a release word's result is registered in the output buffer before it shows on out_
// throughput: one sample word per cycle; in_tready drops only while both result
//   buffer entries are full, set by the two-entry output buffer
// reset: synchronous active-low rst_n clears the press state and buffer and
//   loads debounce_ticks = 20, long_press_ticks = 3000
`default_nettype none
module button_debounce_short_long_press_unit
  import bdsl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // in_tdata: [0] button_level, [7:1] zero
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [InDataWidth-1:0]  in_tdata,
  // out_tdata: [0] long_press, [32:1] held_ticks_out, [39:33] zero
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OutDataWidth-1:0]      out_tdata,
  // configuration write channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index,
  input  wire logic [CfgDataWidth-1:0] cfg_data
);

  logic [DebWidth-1:0]  debounce_ticks_r;
  logic [HeldWidth-1:0] long_press_ticks_r;
  logic                 in_accept;
  logic                 res_valid;
  logic                 res_push;
  logic                 push_ready;
  press_result_t        res_data;
  press_result_t        out_data;
  trk_status_t          status;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= DebResetVal;
      long_press_ticks_r <= LongResetVal;
    end else if (cfg_valid) begin
      if (cfg_index == CfgDebounceTicks) begin
        debounce_ticks_r <= cfg_data[DebWidth-1:0];
      end else if (cfg_index == CfgLongPressTicks) begin
        long_press_ticks_r <= cfg_data[HeldWidth-1:0];
      end
    end
  end

  assign in_tready = push_ready;
  assign in_accept = in_tvalid && in_tready;
  assign res_push  = res_valid;

  bdsl_tracker u_tracker (
    .clk              (clk),
    .rst_n            (rst_n),
    .sample_en        (in_accept),
    .button_level     (in_tdata[0]),
    .debounce_ticks   (debounce_ticks_r),
    .long_press_ticks (long_press_ticks_r),
    .res_valid        (res_valid),
    .res_data         (res_data),
    .status           (status)
  );

  bdsl_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res_data),
    .push_ready (push_ready),
    .out_valid  (out_tvalid),
    .out_data   (out_data),
    .out_ready  (out_tready)
  );

  // output packing
  assign out_tdata = {{(OutDataWidth - HeldWidth - 1){1'b0}},
                      out_data.held_ticks_out, out_data.long_press};

  // a reported release leaves the tracker released
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !status.pressed)
    else $error("tracker still pressed after release report");

  // held time and long flag only exist while pressed
  a_held_only_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (status.held_nonzero || status.long_seen) |-> status.pressed)
    else $error("held state set while released");

  // a result is only produced by an accepted release word
  a_result_from_release: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (in_accept && !in_tdata[0] && status.pressed))
    else $error("result without accepted release");

  // the output is valid in the cycle after a result is produced
  a_result_visible: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> out_tvalid)
    else $error("pushed result not visible on output");

endmodule
`default_nettype wire

>>> rtl/core/bdsl_tracker.sv
// debounce and held-time tracker, one sample word per cycle while sample_en is high
`default_nettype none
module bdsl_tracker
  import bdsl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 sample_en,
  input  wire logic                 button_level,
  input  wire logic [DebWidth-1:0]  debounce_ticks,
  input  wire logic [HeldWidth-1:0] long_press_ticks,
  output logic                      res_valid,
  output press_result_t             res_data,
  output trk_status_t               status
);

  logic                 pressed_r, pressed_nxt;
  logic [DebWidth-1:0]  stable_r, stable_nxt;
  logic [HeldWidth-1:0] held_r, held_nxt;
  logic                 long_r, long_nxt;

  logic [HeldWidth-1:0] held_inc;
  logic [DebWidth-1:0]  stable_inc;
  logic                 long_upd;
  logic                 accept;

  // per-sample update
  always_comb begin
    held_inc   = held_r;
    long_upd   = long_r;
    stable_inc = stable_r;
    accept     = 1'b0;
    if (pressed_r) begin
      if (held_r != {HeldWidth{1'b1}}) begin
        held_inc = held_r + 1'b1;
      end
      if (held_inc >= long_press_ticks) begin
        long_upd = 1'b1;
      end
    end
    if (stable_r != {DebWidth{1'b1}}) begin
      stable_inc = stable_r + 1'b1;
    end
    if (button_level != pressed_r) begin
      accept = (stable_inc >= debounce_ticks);
    end

    pressed_nxt = pressed_r;
    held_nxt    = held_inc;
    long_nxt    = long_upd;
    stable_nxt  = (button_level == pressed_r) ? '0 : stable_inc;
    res_valid   = 1'b0;
    if (accept) begin
      stable_nxt  = '0;
      held_nxt    = '0;
      long_nxt    = 1'b0;
      pressed_nxt = button_level;
      res_valid   = sample_en && !button_level;
    end
    res_data.long_press     = long_upd;
    res_data.held_ticks_out = held_inc;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      stable_r  <= '0;
      held_r    <= '0;
      long_r    <= 1'b0;
    end else if (sample_en) begin
      pressed_r <= pressed_nxt;
      stable_r  <= stable_nxt;
      held_r    <= held_nxt;
      long_r    <= long_nxt;
    end
  end

  assign status.pressed      = pressed_r;
  assign status.held_nonzero = (held_r != '0);
  assign status.long_seen    = long_r;

endmodule
`default_nettype wire

>>> rtl/core/bdsl_out_skid.sv
// two-entry result buffer between the tracker and the output stream
`default_nettype none
module bdsl_out_skid
  import bdsl_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire press_result_t push_data,
  output logic               push_ready,
  output logic               out_valid,
  output press_result_t      out_data,
  input  wire logic          out_ready
);

  logic          main_valid_r;
  logic          skid_valid_r;
  press_result_t main_r;
  press_result_t skid_r;
  logic          pop;

  assign pop        = main_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= push_data;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_button_debounce_short_long_press_unit.sv
// testbench for the button debounce short/long press unit: sample stimulus, press report checks
`timescale 1ns / 1ps
module tb_button_debounce_short_long_press_unit;
  import bdsl_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomItems = 1850;
  localparam int unsigned PhaseCount = 8;
  localparam logic [CfgIdxWidth-1:0] CfgIdxUnused = CfgIdxWidth'(2);
  localparam logic [CfgIdxWidth-1:0] CfgIdxTop = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // in_tdata: [0] button_level, [7:1] zero
  logic [InDataWidth-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // out_tdata: [0] long_press, [32:1] held_ticks_out, [39:33] zero
  logic [OutDataWidth-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  button_debounce_short_long_press_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // pending samples and expected press reports
  logic tick_q[$];
  press_result_t report_q[$];
  int unsigned queued = 0;
  int unsigned mismatches = 0;

  // idling controls
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_ticket = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_cnt = 0;

  // handshake flags seen at the last rising edge
  logic in_taken = 1'b0;
  logic cfg_done = 1'b0;
  int unsigned quiet = 0;

  // predictor state and register copies
  logic pressed = 1'b0;
  logic [DebWidth-1:0] stable_cnt = '0;
  logic [HeldWidth-1:0] held_cnt = '0;
  logic long_flag = 1'b0;
  logic [DebWidth-1:0] deb_len = DebResetVal;
  logic [HeldWidth-1:0] long_len = LongResetVal;

  initial begin
    forever #4 clk = ~clk;
  end

  // one sample tick of the debounce and press timer
  task automatic predict_tick(input logic lvl);
    logic accept;
    press_result_t rep;
    accept = 1'b0;
    if (pressed) begin
      if (held_cnt != '1) held_cnt = held_cnt + 1'b1;
      if (held_cnt >= long_len) long_flag = 1'b1;
    end
    if (lvl == pressed) begin
      stable_cnt = '0;
    end else begin
      if (stable_cnt != '1) stable_cnt = stable_cnt + 1'b1;
      accept = (stable_cnt >= deb_len);
    end
    if (accept) begin
      // a release closes the press and reports it
      if (!lvl) begin
        rep.long_press = long_flag || (held_cnt >= long_len);
        rep.held_ticks_out = held_cnt;
        report_q.push_back(rep);
      end
      pressed = lvl;
      held_cnt = '0;
      long_flag = 1'b0;
      stable_cnt = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
    $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
    mismatches++;
  endtask

  // sample driver
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (rst_n && tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= {{(InDataWidth-1){1'b0}}, tick_q.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
        in_tdata <= {{(InDataWidth-1){1'b0}}, 1'($urandom_range(1))};
      end
    end
  end

  // report receiver, with random stalls and a long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_cnt <= HoldCycles;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: check reports, track register writes, predict each sample word
  always @(posedge clk) begin : monitor
    press_result_t want;
    press_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = press_result_t'(out_tdata[32:0]);
        if (report_q.size() == 0) begin
          report_mismatch("unexpected report", '0, out_tdata);
        end else begin
          want = report_q.pop_front();
          if (got.long_press !== want.long_press)
            report_mismatch("long_press", 40'(want.long_press), 40'(got.long_press));
          if (got.held_ticks_out !== want.held_ticks_out)
            report_mismatch("held_ticks_out", 40'(want.held_ticks_out),
                            40'(got.held_ticks_out));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgDebounceTicks: deb_len = cfg_data[DebWidth-1:0];
          CfgLongPressTicks: long_len = cfg_data[HeldWidth-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_tick(in_tdata[0]);
    end
    in_taken <= rst_n && in_tvalid && in_tready;
    cfg_done <= rst_n && cfg_valid && cfg_ready;
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_done);
    cfg_valid = 1'b0;
  endtask

  // all samples sent, all reports back, then a settle wait
  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (tick_q.size() != 0 || in_tvalid || report_q.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic push_run(input logic lvl, input int unsigned n);
    repeat (n) begin
      tick_q.push_back(lvl);
      queued++;
    end
  endtask

  // bounce: runs of the other level too short to be accepted
  task automatic push_bounce(input logic lvl, input int unsigned need);
    if (need > 1) begin
      repeat ($urandom_range(0, 2)) begin
        push_run(lvl, $urandom_range(1, need - 1));
        push_run(!lvl, $urandom_range(1, 3));
      end
    end
  endtask

  // a whole press: bouncy press, hold with glitches, bouncy release
  task automatic queue_press(input int unsigned deb);
    int unsigned need;
    need = (deb == 0) ? 1 : deb;
    push_run(1'b0, $urandom_range(0, 2));
    push_bounce(1'b1, need);
    push_run(1'b1, need + $urandom_range(0, 20));
    push_bounce(1'b0, need);
    push_run(1'b1, $urandom_range(0, 20));
    push_bounce(1'b0, need);
    push_run(1'b0, need);
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 12)) push_run(1'($urandom_range(1)), 1);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_end;
    int unsigned deb;
    logic [HeldWidth-1:0] long_thr;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero debounce and zero threshold: every change accepted at once, every press long
    write_reg(CfgDebounceTicks, '0);
    write_reg(CfgLongPressTicks, '0);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 3);
    push_run(1'b0, 1);
    wait_idle();

    // unused indexes must leave both registers alone
    write_reg(CfgIdxUnused, '1);
    write_reg(CfgIdxTop, 32'h0000_0007);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    wait_idle();

    // upper data bits dropped for the debounce length; threshold hit exactly on release
    write_reg(CfgDebounceTicks, 32'h5A5A_0001);
    write_reg(CfgLongPressTicks, 32'd2);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 2);
    push_run(1'b0, 1);
    wait_idle();

    // largest settings: nothing gets accepted
    write_reg(CfgDebounceTicks, 32'h0000_FFFF);
    write_reg(CfgLongPressTicks, '1);
    push_run(1'b1, 3);
    push_run(1'b0, 2);
    wait_idle();

    // receiver holds off while short presses keep coming, so the input stalls
    write_reg(CfgDebounceTicks, 32'd1);
    write_reg(CfgLongPressTicks, 32'd3);
    hold_ticket++;
    repeat (16) begin
      push_run(1'b1, $urandom_range(1, 5));
      push_run(1'b0, 1);
    end
    wait_idle();

    // random presses under several settings and idle patterns
    for (phase = 0; phase < PhaseCount; phase++) begin
      deb = (phase == 5) ? $urandom_range(16, 40) : $urandom_range(0, 5);
      long_thr = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 40);
      write_reg(CfgDebounceTicks, deb);
      write_reg(CfgLongPressTicks, long_thr);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct = 7;
          recv_stall_pct = 7;
        end
      endcase
      phase_end = queued + RandomItems / PhaseCount;
      while (queued < phase_end) begin
        if ($urandom_range(9) < 8) queue_press(deb);
        else queue_noise();
      end
      wait_idle();
    end

    if (mismatches == 0 && report_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bdsl_pkg.sv
rtl/core/bdsl_tracker.sv
rtl/core/bdsl_out_skid.sv
rtl/core/button_debounce_short_long_press_unit.sv
tb/tb_button_debounce_short_long_press_unit.sv
